### rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a condition at the edge after a trigger.
`define ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

### rtl/rpet_pkg.sv
`default_nettype none

package rpet_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 6;

  localparam logic signed [7:0] STRENGTH_LO = -8'sd100;
  localparam logic signed [7:0] STRENGTH_HI = -8'sd30;

  localparam logic signed [7:0] CAUGHT_LEVEL_RST   = -8'sd48;
  localparam logic [15:0]       CAUGHT_HOLD_RST    = 16'd5000;
  localparam logic [23:0]       STALL_MS_RST       = 24'd60000;
  localparam logic [6:0]        TREND_DEADBAND_RST = 7'd3;
  localparam logic signed [7:0] HOT_LEVEL_RST      = -8'sd35;
  localparam logic [6:0]        RELEASE_MARGIN_RST = 7'd10;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_CAUGHT_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAUGHT_HOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_MS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TREND_DEADBAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_LEVEL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MARGIN = 3'd5;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [1:0] {
    TREND_WAIT   = 2'd0,
    TREND_WARMER = 2'd1,
    TREND_COLDER = 2'd2,
    TREND_STEADY = 2'd3
  } trend_t;

  typedef struct packed {
    logic              cmd;
    logic [31:0]       now_ms;
    logic              sample_valid;
    logic signed [7:0] rssi;
  } item_t;

  typedef struct packed {
    logic              started;
    logic              signal_found;
    logic              stalled;
    logic              hot_event;
    logic              warmer_event;
    logic              colder_event;
    logic              catch_event;
    logic              caught;
    trend_t            trend;
    logic [6:0]        strength;
    logic signed [7:0] latest_rssi;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_beat_t;

  typedef struct packed {
    logic              has_one;
    logic              has_two;
    logic signed [7:0] latest;
    logic signed [7:0] prev;
    logic signed [7:0] oldest;
  } hist_view_t;

  function automatic logic hold_live(input logic [31:0] until_ms, input logic [31:0] now_ms);
    logic [31:0] d;
    d = until_ms - now_ms;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

`default_nettype wire

### rtl/rpet_stream_if.sv
`default_nettype none

interface rpet_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/rssi_proximity_event_tracker_core.sv
// Signal strength hunt tracker. Takes one item (start or tick) per clock while results are
// taken, and gives one result per item. An accepted item sits in an input register; once the
// result register is empty or being read, it is evaluated against the hunt state and the
// strength history and written to the result register, which offers the result until taken.
// While a result waits, an empty input register still takes one item and then holds it until
// the result moves on. The history is a shift line of HISTORY_DEPTH samples with fixed taps.
// Configuration writes are taken at any cycle and must only happen while no item is in flight.
`default_nettype none

module rssi_proximity_event_tracker_core #(
  parameter int unsigned HISTORY_DEPTH = rpet_pkg::HISTORY_DEPTH_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  rpet_stream_if.sink   item_in,
  rpet_stream_if.source result_out,
  rpet_stream_if.sink   cfg
);
  import rpet_pkg::*;

  logic signed [7:0] caught_level;
  logic [15:0]       caught_hold_ms;
  logic [23:0]       stall_ms;
  logic [6:0]        trend_deadband;
  logic signed [7:0] hot_level;
  logic [6:0]        release_margin;

  item_t      ireg;
  logic       ireg_valid;
  result_t    res, res_next;
  logic       res_valid;
  logic       advance;
  logic       is_start;
  hist_view_t view;

  trend_t      last_trend, last_trend_next;
  logic        hot_armed_off, hot_armed_off_next;
  logic        ever_hot, ever_hot_next;
  logic        seen_signal, seen_signal_next;
  logic        stall_done, stall_done_next;
  logic        catch_done, catch_done_next;
  logic [31:0] start_time, start_time_next;
  logic [31:0] caught_until, caught_until_next;

  logic signed [7:0] clamped;
  logic [7:0]        strength_sum;
  logic signed [8:0] delta;
  logic signed [8:0] band;
  logic signed [8:0] release_lvl;
  logic              hot_hit;
  logic              catch_hit;
  trend_t            cur_trend;

  // config writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      caught_level   <= CAUGHT_LEVEL_RST;
      caught_hold_ms <= CAUGHT_HOLD_RST;
      stall_ms       <= STALL_MS_RST;
      trend_deadband <= TREND_DEADBAND_RST;
      hot_level      <= HOT_LEVEL_RST;
      release_margin <= RELEASE_MARGIN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        CFG_CAUGHT_LEVEL:   caught_level   <= cfg.data.value[7:0];
        CFG_CAUGHT_HOLD:    caught_hold_ms <= cfg.data.value[15:0];
        CFG_STALL_MS:       stall_ms       <= cfg.data.value;
        CFG_TREND_DEADBAND: trend_deadband <= cfg.data.value[6:0];
        CFG_HOT_LEVEL:      hot_level      <= cfg.data.value[7:0];
        CFG_RELEASE_MARGIN: release_margin <= cfg.data.value[6:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance          = ireg_valid && (!res_valid || result_out.ready);
  assign item_in.ready    = !ireg_valid || advance;
  assign result_out.valid = res_valid;
  assign result_out.data  = res;
  assign is_start         = (ireg.cmd == CMD_START);

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (item_in.ready) begin
        ireg_valid <= item_in.valid;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (result_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      ireg <= item_in.data;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  rpet_hist #(.DEPTH(HISTORY_DEPTH)) u_hist (
    .clk    (clk),
    .rst    (rst),
    .clear  (is_start),
    .add    (!is_start && ireg.sample_valid),
    .commit (advance),
    .sample (ireg.rssi),
    .view   (view)
  );

  // per-item datapath
  always_comb begin
    if (view.latest < STRENGTH_LO) begin
      clamped = STRENGTH_LO;
    end else if (view.latest > STRENGTH_HI) begin
      clamped = STRENGTH_HI;
    end else begin
      clamped = view.latest;
    end
  end

  assign strength_sum = clamped - STRENGTH_LO;
  assign hot_hit      = view.has_one && (clamped >= hot_level);
  assign catch_hit    = view.has_two && (view.latest >= caught_level) &&
                        (view.prev >= caught_level);
  assign release_lvl  = $signed({caught_level[7], caught_level}) -
                        $signed({2'b00, release_margin});
  assign delta        = $signed({view.latest[7], view.latest}) -
                        $signed({view.oldest[7], view.oldest});
  assign band         = $signed({2'b00, trend_deadband});

  always_comb begin
    priority if (delta > band) begin
      cur_trend = TREND_WARMER;
    end else if (delta < -band) begin
      cur_trend = TREND_COLDER;
    end else begin
      cur_trend = TREND_STEADY;
    end
  end

  always_comb begin
    last_trend_next    = last_trend;
    hot_armed_off_next = hot_armed_off;
    ever_hot_next      = ever_hot;
    seen_signal_next   = seen_signal;
    stall_done_next    = stall_done;
    catch_done_next    = catch_done;
    start_time_next    = start_time;
    caught_until_next  = caught_until;
    res_next             = '0;
    res_next.trend       = TREND_WAIT;
    res_next.latest_rssi = STRENGTH_LO;

    if (is_start) begin
      last_trend_next    = TREND_WAIT;
      hot_armed_off_next = 1'b0;
      ever_hot_next      = 1'b0;
      seen_signal_next   = 1'b0;
      stall_done_next    = 1'b0;
      catch_done_next    = 1'b0;
      start_time_next    = ireg.now_ms;
      caught_until_next  = '0;
      res_next.started   = 1'b1;
    end else begin
      if (view.has_one && !seen_signal) begin
        seen_signal_next      = 1'b1;
        res_next.signal_found = 1'b1;
      end
      if (!ever_hot && !stall_done && ((ireg.now_ms - start_time) >= {8'd0, stall_ms})) begin
        stall_done_next  = 1'b1;
        res_next.stalled = 1'b1;
      end
      if (view.has_one) begin
        res_next.latest_rssi = view.latest;
        res_next.strength    = strength_sum[6:0];
      end
      if (hot_hit) begin
        if (!hot_armed_off) begin
          res_next.hot_event = 1'b1;
          hot_armed_off_next = 1'b1;
        end
        ever_hot_next = 1'b1;
      end else begin
        hot_armed_off_next = 1'b0;
      end
      if (catch_hit) begin
        caught_until_next = ireg.now_ms + {16'd0, caught_hold_ms};
        if (!catch_done) begin
          catch_done_next      = 1'b1;
          res_next.catch_event = 1'b1;
        end
      end else if (view.has_one && ($signed({view.latest[7], view.latest}) < release_lvl) &&
                   !hold_live(caught_until, ireg.now_ms)) begin
        catch_done_next = 1'b0;
      end
      if (view.has_two) begin
        res_next.trend = cur_trend;
        if (cur_trend != last_trend) begin
          res_next.warmer_event = (cur_trend == TREND_WARMER);
          res_next.colder_event = (cur_trend == TREND_COLDER);
          last_trend_next       = cur_trend;
        end
      end
    end
    res_next.caught = hold_live(caught_until_next, ireg.now_ms);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_trend    <= TREND_WAIT;
      hot_armed_off <= 1'b0;
      ever_hot      <= 1'b0;
      seen_signal   <= 1'b0;
      stall_done    <= 1'b0;
      catch_done    <= 1'b0;
      start_time    <= '0;
      caught_until  <= '0;
    end else if (advance) begin
      last_trend    <= last_trend_next;
      hot_armed_off <= hot_armed_off_next;
      ever_hot      <= ever_hot_next;
      seen_signal   <= seen_signal_next;
      stall_done    <= stall_done_next;
      catch_done    <= catch_done_next;
      start_time    <= start_time_next;
      caught_until  <= caught_until_next;
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_start_clean, !(res_valid && res.started) || (res.trend == TREND_WAIT && res.strength == 7'd0 && !res.signal_found && !res.hot_event), "start result carries tick events")
  `ASSERT_ALWAYS(a_trend_event, !(res_valid && res.warmer_event) || (res.trend == TREND_WARMER && !res.colder_event), "warmer event without warmer trend")
  `ASSERT_NEXT(a_stall_sticky, stall_done && !(advance && is_start), stall_done, "stall flag dropped within a hunt")

endmodule

`default_nettype wire

### rtl/rpet_hist.sv
`default_nettype none

module rpet_hist #(
  parameter int unsigned DEPTH = rpet_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 clear,
  input  wire logic                 add,
  input  wire logic                 commit,
  input  wire logic signed [7:0]    sample,
  output rpet_pkg::hist_view_t      view
);
  import rpet_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic signed [7:0] taps [DEPTH];
  logic signed [7:0] first_s;
  logic [CNT_W-1:0]  count;
  logic              full;

  assign full = (count == CNT_W'(DEPTH));

  always_comb begin
    if (add) begin
      view.has_one = 1'b1;
      view.has_two = (count != '0);
      view.latest  = sample;
      view.prev    = taps[0];
      view.oldest  = full ? taps[DEPTH-2] : ((count == '0) ? sample : first_s);
    end else begin
      view.has_one = (count != '0);
      view.has_two = (count >= CNT_W'(2));
      view.latest  = taps[0];
      view.prev    = taps[1];
      view.oldest  = full ? taps[DEPTH-1] : first_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit && clear) begin
      count <= '0;
    end else if (commit && add && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (commit && add && !clear) begin
      taps[0] <= sample;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
      if (count == '0) begin
        first_s <= sample;
      end
    end
  end

endmodule

`default_nettype wire
